/* src/pidd_pkg.sv */
package pidd_pkg;

    // Default parameter values
    localparam int FRAC_BITS_DEF = 16;
    localparam int ACC_WIDTH_DEF = 48;

    // Fixed widths
    localparam int DATA_W     = 32;
    localparam int DEADBAND_W = 31;
    localparam int CFG_ADDR_W = 3;
    localparam int MUL_W      = 32;
    localparam int DIV_W      = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] measurement;
        logic        [DATA_W-1:0] delta_t;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic                     in_deadband;
    } out_word_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SET_POINT  = 3'd0,
        CFG_PROP_GAIN  = 3'd1,
        CFG_INTEG_GAIN = 3'd2,
        CFG_DERIV_GAIN = 3'd3,
        CFG_INTEG_MIN  = 3'd4,
        CFG_INTEG_MAX  = 3'd5,
        CFG_DEADBAND   = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SIGN_NONE = 2'd0,
        SIGN_POS  = 2'd1,
        SIGN_NEG  = 2'd2
    } sign_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_MP,
        S_MI,
        S_INC,
        S_ACC,
        S_IMAG,
        S_KLO,
        S_KHI,
        S_ITERM,
        S_CLAMP,
        S_DIV,
        S_DTERM,
        S_SUM,
        S_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* src/pidd_mul.sv */
module pidd_mul (
    input  logic                           clk,
    input  logic                           en,
    input  logic [pidd_pkg::MUL_W-1:0]     a,
    input  logic [pidd_pkg::MUL_W-1:0]     b,
    output logic [2*pidd_pkg::MUL_W-1:0]   prod
);

    logic [2*pidd_pkg::MUL_W-1:0] prod_reg;

    // Unsigned product, registered; hold while idle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

/* src/pidd_div.sv */
module pidd_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [2*pidd_pkg::DIV_W-1:0]   dividend,
    input  logic [pidd_pkg::DIV_W-1:0]     divisor,
    output logic [pidd_pkg::DIV_W-1:0]     quotient,
    output pidd_pkg::div_stat_t            stat
);

    localparam int W     = pidd_pkg::DIV_W;
    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [W:0]       shifted;
    logic [W:0]       trial;
    logic             fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    // The caller guarantees the high half is below the divisor.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[W-1]};
        trial   = shifted - {1'b0, dvs_reg};
        fits    = shifted >= {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[2*W-1:W];
            quo_reg <= dividend[W-1:0];
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[W-1:0] : shifted[W-1:0];
            quo_reg <= {quo_reg[W-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign stat     = '{busy: busy_reg, done: done_reg};

endmodule

/* src/pid_controller_deadband.sv */
// Channel   Direction  Handshake             Word
// in        input      in_valid / in_stall   measurement, delta_t
// out       output     out_valid / out_stall drive, in_deadband
// cfg       input      cfg_en                cfg_addr, cfg_data
//
// A word passes through idle, 13 steps around one shared 32x32 multiplier and the
// bit-serial divider (32 quotient bits, then done); a new word is accepted only in idle.
// Zero delta_t or a saturated quotient skips the divider. in_stall is high from
// acceptance until the result enters the output register; a stalled output holds the
// last step. Reset clears control state, integrator, previous error and out_valid and
// sets the configuration to defaults; datapath and output word registers are not reset.
module pid_controller_deadband #(
    parameter int FRAC_BITS = pidd_pkg::FRAC_BITS_DEF,
    parameter int ACC_WIDTH = pidd_pkg::ACC_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  pidd_pkg::in_word_t                  in_word,
    output logic                                out_valid,
    input  logic                                out_stall,
    output pidd_pkg::out_word_t                 out_word,
    input  logic                                cfg_en,
    input  logic [pidd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [pidd_pkg::DATA_W-1:0]         cfg_data
);

    localparam int DW     = pidd_pkg::DATA_W;
    localparam int MW     = pidd_pkg::MUL_W;
    localparam int PROD_W = 2 * MW;
    localparam int WIDE_W = 3 * MW;
    localparam int IMAG_W = 2 * MW;

    // Saturate a magnitude to a signed 32-bit value of the given sign
    function automatic logic [DW-1:0] sat_mag32(input logic neg, input logic [WIDE_W-1:0] q);
        logic [WIDE_W-1:0] lim;
        logic [WIDE_W-1:0] m;
        lim = neg ? (WIDE_W'(1) << (DW - 1)) : ((WIDE_W'(1) << (DW - 1)) - WIDE_W'(1));
        m   = (q > lim) ? lim : q;
        return neg ? (~m[DW-1:0] + DW'(1)) : m[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] abs32(input logic [DW-1:0] v);
        return v[DW-1] ? (~v + DW'(1)) : v;
    endfunction

    // Configuration registers
    logic signed [DW-1:0]                   set_point_reg;
    logic signed [DW-1:0]                   prop_gain_reg;
    logic signed [DW-1:0]                   integ_gain_reg;
    logic signed [DW-1:0]                   deriv_gain_reg;
    logic signed [DW-1:0]                   integ_min_reg;
    logic signed [DW-1:0]                   integ_max_reg;
    logic [pidd_pkg::DEADBAND_W-1:0]        deadband_reg;
    pidd_pkg::sign_t                        last_sign_reg;

    // Controller state
    logic signed [ACC_WIDTH-1:0]            integ_reg;
    logic signed [ACC_WIDTH-1:0]            integ_next;
    logic signed [DW-1:0]                   prev_err_reg;

    pidd_pkg::state_t                       state_reg;
    pidd_pkg::state_t                       state_next;

    // Datapath registers
    logic signed [DW-1:0]                   meas_reg;
    logic [DW-1:0]                          dt_reg;
    logic signed [DW-1:0]                   err_reg;
    logic [DW-1:0]                          dmag_reg;
    logic                                   dneg_reg;
    logic signed [DW-1:0]                   p_reg;
    logic signed [ACC_WIDTH-1:0]            t_reg;
    logic [IMAG_W-1:0]                      imag_reg;
    logic [PROD_W-1:0]                      lo_reg;
    logic signed [DW-1:0]                   iraw_reg;
    logic signed [DW-1:0]                   i_reg;
    logic                                   dzero_reg;
    logic                                   dovf_reg;
    logic signed [DW-1:0]                   d_reg;
    logic signed [DW-1:0]                   drive_reg;
    logic                                   dead_reg;

    logic                                   out_valid_reg;
    pidd_pkg::out_word_t                    out_word_reg;

    // Shared units
    logic                                   mul_en;
    logic [MW-1:0]                          mul_a;
    logic [MW-1:0]                          mul_b;
    logic [PROD_W-1:0]                      prod;
    logic                                   div_start;
    logic [pidd_pkg::DIV_W-1:0]             quotient;
    pidd_pkg::div_stat_t                    div_stat;
    logic                                   out_load;

    // Combinational datapath
    logic signed [DW:0]                     sp_diff;
    logic signed [DW-1:0]                   err_sat;
    logic [DW-1:0]                          err_mag;
    logic signed [DW:0]                     e_diff;
    logic [DW:0]                            e_diff_mag;
    logic [PROD_W-1:0]                      q_inc;
    logic [PROD_W-1:0]                      inc_lim;
    logic [PROD_W-1:0]                      inc_mag;
    logic signed [ACC_WIDTH-1:0]            t_val;
    logic signed [ACC_WIDTH:0]              acc_sum;
    logic signed [ACC_WIDTH-1:0]            acc_sat;
    logic [ACC_WIDTH-1:0]                   integ_abs;
    logic [WIDE_W-1:0]                      i_wide;
    logic signed [DW-1:0]                   i_clamp;
    logic                                   d_ovf;
    logic signed [DW+1:0]                   term_sum;
    logic signed [DW-1:0]                   drive_sat;
    logic                                   sp_clear;
    pidd_pkg::sign_t                        sp_sign;

    pidd_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    pidd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod),
        .divisor  (dt_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    always_comb
    begin
        // error = set point - measurement, saturated
        sp_diff = (DW + 1)'(set_point_reg) - (DW + 1)'(meas_reg);
        if (sp_diff[DW] != sp_diff[DW-1])
        begin
            err_sat = sp_diff[DW] ? {1'b1, {(DW - 1){1'b0}}} : {1'b0, {(DW - 1){1'b1}}};
        end
        else
        begin
            err_sat = sp_diff[DW-1:0];
        end
        err_mag = abs32(err_reg);

        // change in error since the last sample
        e_diff     = (DW + 1)'(err_reg) - (DW + 1)'(prev_err_reg);
        e_diff_mag = e_diff[DW] ? ((DW + 1)'(0) - e_diff) : e_diff;

        // integrator increment: error * dt, scaled and saturated to the accumulator
        q_inc   = prod >> FRAC_BITS;
        inc_lim = err_reg[DW-1] ? (PROD_W'(1) << (ACC_WIDTH - 1))
                                : ((PROD_W'(1) << (ACC_WIDTH - 1)) - PROD_W'(1));
        inc_mag = (q_inc > inc_lim) ? inc_lim : q_inc;
        t_val   = err_reg[DW-1] ? (~inc_mag[ACC_WIDTH-1:0] + ACC_WIDTH'(1))
                                : inc_mag[ACC_WIDTH-1:0];

        // saturating integrator add
        acc_sum = (ACC_WIDTH + 1)'(integ_reg) + (ACC_WIDTH + 1)'(t_reg);
        if (acc_sum[ACC_WIDTH] != acc_sum[ACC_WIDTH-1])
        begin
            acc_sat = acc_sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH - 1){1'b0}}}
                                         : {1'b0, {(ACC_WIDTH - 1){1'b1}}};
        end
        else
        begin
            acc_sat = acc_sum[ACC_WIDTH-1:0];
        end
        integ_abs = integ_reg[ACC_WIDTH-1] ? (~integ_reg + ACC_WIDTH'(1)) : integ_reg;

        // integrator * Ki from two partial products
        i_wide = ({prod, {MW{1'b0}}} + {{MW{1'b0}}, lo_reg}) >> FRAC_BITS;

        // lower clamp wins when the limits cross
        i_clamp = iraw_reg;
        if (i_clamp > integ_max_reg)
        begin
            i_clamp = integ_max_reg;
        end
        if (i_clamp < integ_min_reg)
        begin
            i_clamp = integ_min_reg;
        end

        // quotient would not fit in 32 bits
        d_ovf = prod[PROD_W-1:MW] >= dt_reg;

        term_sum = (DW + 2)'(p_reg) + (DW + 2)'(i_reg) + (DW + 2)'(d_reg);
        if ((term_sum[DW+1:DW-1] != 3'b000) && (term_sum[DW+1:DW-1] != 3'b111))
        begin
            drive_sat = term_sum[DW+1] ? {1'b1, {(DW - 1){1'b0}}} : {1'b0, {(DW - 1){1'b1}}};
        end
        else
        begin
            drive_sat = term_sum[DW-1:0];
        end

        // a set point of opposite sign to the last nonzero one clears the integrator
        sp_sign  = cfg_data[DW-1] ? pidd_pkg::SIGN_NEG : pidd_pkg::SIGN_POS;
        sp_clear = cfg_en && (cfg_addr == pidd_pkg::CFG_SET_POINT) && (cfg_data != '0)
                   && (last_sign_reg != pidd_pkg::SIGN_NONE) && (last_sign_reg != sp_sign);

        integ_next = integ_reg;
        if (sp_clear)
        begin
            integ_next = '0;
        end
        else if (state_reg == pidd_pkg::S_ACC)
        begin
            integ_next = acc_sat;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_point_reg  <= '0;
            prop_gain_reg  <= '0;
            integ_gain_reg <= '0;
            deriv_gain_reg <= '0;
            integ_min_reg  <= {1'b1, {(DW - 1){1'b0}}};
            integ_max_reg  <= {1'b0, {(DW - 1){1'b1}}};
            deadband_reg   <= '0;
            last_sign_reg  <= pidd_pkg::SIGN_NONE;
        end
        else if (cfg_en)
        begin
            case (cfg_addr)
                pidd_pkg::CFG_SET_POINT:
                begin
                    set_point_reg <= cfg_data;
                    if (cfg_data != '0)
                    begin
                        last_sign_reg <= sp_sign;
                    end
                end
                pidd_pkg::CFG_PROP_GAIN:  prop_gain_reg  <= cfg_data;
                pidd_pkg::CFG_INTEG_GAIN: integ_gain_reg <= cfg_data;
                pidd_pkg::CFG_DERIV_GAIN: deriv_gain_reg <= cfg_data;
                pidd_pkg::CFG_INTEG_MIN:  integ_min_reg  <= cfg_data;
                pidd_pkg::CFG_INTEG_MAX:  integ_max_reg  <= cfg_data;
                pidd_pkg::CFG_DEADBAND:   deadband_reg   <= cfg_data[pidd_pkg::DEADBAND_W-1:0];
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pidd_pkg::S_IDLE;
            integ_reg     <= '0;
            prev_err_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            integ_reg <= integ_next;
            if (state_reg == pidd_pkg::S_SUM)
            begin
                prev_err_reg <= err_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Sequencer: next step, multiplier operands, divider start, output load
    always_comb
    begin
        state_next = state_reg;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            pidd_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = pidd_pkg::S_ERR;
                end
            end
            pidd_pkg::S_ERR:  state_next = pidd_pkg::S_MP;
            pidd_pkg::S_MP:
            begin
                mul_en     = 1'b1;
                mul_a      = err_mag;
                mul_b      = abs32(prop_gain_reg);
                state_next = pidd_pkg::S_MI;
            end
            pidd_pkg::S_MI:
            begin
                mul_en     = 1'b1;
                mul_a      = err_mag;
                mul_b      = dt_reg;
                state_next = pidd_pkg::S_INC;
            end
            pidd_pkg::S_INC:  state_next = pidd_pkg::S_ACC;
            pidd_pkg::S_ACC:  state_next = pidd_pkg::S_IMAG;
            pidd_pkg::S_IMAG: state_next = pidd_pkg::S_KLO;
            pidd_pkg::S_KLO:
            begin
                mul_en     = 1'b1;
                mul_a      = imag_reg[MW-1:0];
                mul_b      = abs32(integ_gain_reg);
                state_next = pidd_pkg::S_KHI;
            end
            pidd_pkg::S_KHI:
            begin
                mul_en     = 1'b1;
                mul_a      = imag_reg[IMAG_W-1:MW];
                mul_b      = abs32(integ_gain_reg);
                state_next = pidd_pkg::S_ITERM;
            end
            pidd_pkg::S_ITERM:
            begin
                mul_en     = 1'b1;
                mul_a      = dmag_reg;
                mul_b      = abs32(deriv_gain_reg);
                state_next = pidd_pkg::S_CLAMP;
            end
            pidd_pkg::S_CLAMP:
            begin
                if ((dt_reg != '0) && !d_ovf)
                begin
                    div_start  = 1'b1;
                    state_next = pidd_pkg::S_DIV;
                end
                else
                begin
                    state_next = pidd_pkg::S_DTERM;
                end
            end
            pidd_pkg::S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = pidd_pkg::S_DTERM;
                end
            end
            pidd_pkg::S_DTERM: state_next = pidd_pkg::S_SUM;
            pidd_pkg::S_SUM:   state_next = pidd_pkg::S_OUT;
            pidd_pkg::S_OUT:
            begin
                // advance once the output register is free or being emptied
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = pidd_pkg::S_IDLE;
                end
            end
            default: state_next = pidd_pkg::S_IDLE;
        endcase
    end

    // Datapath registers, loaded by step
    always_ff @(posedge clk)
    begin
        case (state_reg)
            pidd_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    meas_reg <= in_word.measurement;
                    dt_reg   <= in_word.delta_t;
                end
            end
            pidd_pkg::S_ERR: err_reg <= err_sat;
            pidd_pkg::S_MP:
            begin
                dmag_reg <= e_diff_mag[DW-1:0];
                dneg_reg <= e_diff[DW] ^ deriv_gain_reg[DW-1];
            end
            pidd_pkg::S_MI:
            begin
                p_reg <= sat_mag32(err_reg[DW-1] ^ prop_gain_reg[DW-1],
                                   WIDE_W'(prod >> FRAC_BITS));
            end
            pidd_pkg::S_INC:  t_reg    <= t_val;
            pidd_pkg::S_IMAG: imag_reg <= IMAG_W'(integ_abs);
            pidd_pkg::S_KHI:  lo_reg   <= prod;
            pidd_pkg::S_ITERM:
            begin
                iraw_reg <= sat_mag32(integ_reg[ACC_WIDTH-1] ^ integ_gain_reg[DW-1], i_wide);
            end
            pidd_pkg::S_CLAMP:
            begin
                i_reg     <= i_clamp;
                dzero_reg <= (dt_reg == '0);
                dovf_reg  <= d_ovf;
            end
            pidd_pkg::S_DTERM:
            begin
                if (dzero_reg)
                begin
                    d_reg <= '0;
                end
                else if (dovf_reg)
                begin
                    d_reg <= sat_mag32(dneg_reg, '1);
                end
                else
                begin
                    d_reg <= sat_mag32(dneg_reg, WIDE_W'(quotient));
                end
            end
            pidd_pkg::S_SUM:
            begin
                dead_reg  <= err_mag < {1'b0, deadband_reg};
                drive_reg <= drive_sat;
            end
            default: ;
        endcase
    end

    // Output register: drop drive to zero inside the deadband
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_word_reg.drive       <= dead_reg ? '0 : drive_reg;
            out_word_reg.in_deadband <= dead_reg;
        end
    end

    assign in_stall  = (state_reg != pidd_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // The divider only runs while the sequencer waits for it
    a_div_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == pidd_pkg::S_DIV))
        else $error("divider busy outside its step");

    // A new result appears only from the output step
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == pidd_pkg::S_OUT))
        else $error("output word loaded outside the output step");

    // A deadband result carries zero drive
    a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.in_deadband) |-> (out_word_reg.drive == '0))
        else $error("deadband word with nonzero drive");

endmodule
